### design/group_tagged_list_store_macros.svh
// assertion macros for the group tagged list store
// used by the top level only, no other dependencies
`ifndef GROUP_TAGGED_LIST_STORE_MACROS_SVH
`define GROUP_TAGGED_LIST_STORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define GTLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtls assertion failed");

// next-cycle implication, checked out of reset
`define GTLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtls assertion failed");

`endif

### design/gtls_pkg.sv
// shared types, codes and defaults for the group tagged list store
// no dependencies; used by every module of the block
package gtls_pkg;

   // parameter defaults
   localparam int DEPTH_DEF       = 16;
   localparam int ITEM_WIDTH_DEF  = 16;
   localparam int GROUP_WIDTH_DEF = 8;

   // fixed field widths of the channels
   localparam int OP_W     = 2;
   localparam int ITEM_W   = 16;
   localparam int GROUP_W  = 8;
   localparam int STATUS_W = 2;
   localparam int REMOVED_W = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LISTED  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [ITEM_W-1:0]  item;
      logic [GROUP_W-1:0]        group;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [ITEM_W-1:0]  item_res;
      logic [REMOVED_W-1:0]      removed_count;
      logic                      last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;      // transaction accepted
      logic step;       // move the walk to the next entry
      logic emit_mid;   // send the held listed item, not the last
      logic emit_end;   // send the closing result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] req_op;
      logic [OP_W-1:0] op;
      logic            scan_end;
      logic            is_match;
      logic            pend_valid;
      logic            out_free;
   } stat_type;

endpackage

### design/group_tagged_list_store.sv
// channel   direction  payload             handshake
// req       in         gtls_pkg::req_type  req_valid / req_stall
// rsp       out        gtls_pkg::rsp_type  rsp_valid / rsp_stall
//
// append and clear need no walk; list and remove walk the stored entries,
// one stored entry per cycle through the single read port of the entry memory
// each listed match past the first waits while the result register is stalled
// reset empties the store at once (entry count only, the memory is not swept)
// a new transaction is taken once the previous closing result is loaded
//
// top level of the group tagged list store; depends on gtls_pkg, gtls_ctrl,
// gtls_dp and group_tagged_list_store_macros.svh
`include "group_tagged_list_store_macros.svh"

module group_tagged_list_store #(
   parameter int DEPTH       = gtls_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH  = gtls_pkg::ITEM_WIDTH_DEF,
   parameter int GROUP_WIDTH = gtls_pkg::GROUP_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gtls_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gtls_pkg::rsp_type  rsp_data
);

   gtls_pkg::cmd_type  cmd;
   gtls_pkg::stat_type stat;

   // sequencer
   gtls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result path
   gtls_dp #(
      .DEPTH       (DEPTH),
      .ITEM_WIDTH  (ITEM_WIDTH),
      .GROUP_WIDTH (GROUP_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // busy right after a transaction is taken
   `GTLS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // only listed items may come without the last marker
   `GTLS_ASSERT_NOW(a_last_unless_listed, clock, reset,
      rsp_valid && rsp_data.status != gtls_pkg::ST_LISTED, rsp_data.last)
   // the closing result frees the input side
   `GTLS_ASSERT_NEXT(a_idle_after_close, clock, reset, cmd.emit_end, !req_stall)

endmodule

### design/gtls_ctrl.sv
// controller state machine for the group tagged list store
// depends on gtls_pkg; drives gtls_dp through cmd_type
module gtls_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gtls_pkg::stat_type  stat,
   output gtls_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (stat.req_op == gtls_pkg::OP_LIST || stat.req_op == gtls_pkg::OP_REMOVE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_FINISH;
            end else if (stat.op == gtls_pkg::OP_LIST && stat.is_match && stat.pend_valid) begin
               // a newer match pushes the held one out as a middle result
               if (stat.out_free) begin
                  cmd.emit_mid = 1'b1;
                  cmd.step     = 1'b1;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### design/gtls_dp.sv
// datapath for the group tagged list store: entry memory, walk counters,
// held match and result register; depends on gtls_pkg, driven by gtls_ctrl
module gtls_dp #(
   parameter int DEPTH       = gtls_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH  = gtls_pkg::ITEM_WIDTH_DEF,
   parameter int GROUP_WIDTH = gtls_pkg::GROUP_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  gtls_pkg::req_type   req_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output gtls_pkg::rsp_type   rsp_data,
   input  gtls_pkg::cmd_type   cmd,
   output gtls_pkg::stat_type  stat
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // entry memory, one write and one registered read per cycle
   logic [ITEM_WIDTH-1:0]  mem_item  [DEPTH];
   logic [GROUP_WIDTH-1:0] mem_group [DEPTH];

   logic [CNT_W-1:0]       i_ff, i_in;
   logic [CNT_W-1:0]       w_ff, w_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [gtls_pkg::OP_W-1:0] op_ff, op_in;
   logic [GROUP_WIDTH-1:0] grp_ff, grp_in;
   logic                   full_ff, full_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [ITEM_WIDTH-1:0]  pend_item_ff, pend_item_in;
   logic [ITEM_WIDTH-1:0]  rd_item_ff;
   logic [GROUP_WIDTH-1:0] rd_group_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   gtls_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ITEM_WIDTH-1:0]  wr_item;
   logic [GROUP_WIDTH-1:0] wr_group;
   logic [IDX_W-1:0]       rd_addr;
   logic                   is_match;
   logic                   out_free;
   logic                   store_full;

   assign is_match   = (rd_group_ff == grp_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign store_full = (count_ff >= CNT_W'(DEPTH));
   // read data always belongs to the entry at i_ff
   assign rd_addr    = i_in[IDX_W-1:0];

   // counters, held match, memory write port and result loading
   always_comb begin
      i_in          = i_ff;
      w_in          = w_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      grp_in        = grp_ff;
      full_in       = full_ff;
      pend_valid_in = pend_valid_ff;
      pend_item_in  = pend_item_ff;
      wr_en         = 1'b0;
      wr_addr       = w_ff[IDX_W-1:0];
      wr_item       = rd_item_ff;
      wr_group      = rd_group_ff;
      rsp_in        = rsp_ff;

      if (cmd.start) begin
         i_in          = '0;
         w_in          = '0;
         op_in         = req_data.operation;
         grp_in        = GROUP_WIDTH'(req_data.group);
         full_in       = store_full;
         pend_valid_in = 1'b0;
         if (req_data.operation == gtls_pkg::OP_APPEND && !store_full) begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_item  = ITEM_WIDTH'($unsigned(req_data.item));
            wr_group = GROUP_WIDTH'(req_data.group);
            count_in = count_ff + 1'b1;
         end
         if (req_data.operation == gtls_pkg::OP_CLEAR) begin
            count_in = '0;
         end
      end

      // one entry of the walk
      if (cmd.step) begin
         i_in = i_ff + 1'b1;
         if (op_ff == gtls_pkg::OP_LIST && is_match) begin
            pend_item_in  = rd_item_ff;
            pend_valid_in = 1'b1;
         end
         if (op_ff == gtls_pkg::OP_REMOVE && !is_match) begin
            // keep this entry, compacted down to the write pointer
            wr_en = 1'b1;
            w_in  = w_ff + 1'b1;
         end
      end

      if (cmd.emit_mid) begin
         rsp_in.status        = gtls_pkg::ST_LISTED;
         rsp_in.item_res      = gtls_pkg::ITEM_W'(pend_item_ff);
         rsp_in.removed_count = '0;
         rsp_in.last          = 1'b0;
      end

      // closing result of the transaction
      if (cmd.emit_end) begin
         rsp_in.status        = gtls_pkg::ST_OK;
         rsp_in.item_res      = '0;
         rsp_in.removed_count = '0;
         rsp_in.last          = 1'b1;
         pend_valid_in        = 1'b0;
         case (op_ff)
            gtls_pkg::OP_APPEND: begin
               if (full_ff) begin
                  rsp_in.status = gtls_pkg::ST_FULL;
               end
            end
            gtls_pkg::OP_LIST: begin
               if (pend_valid_ff) begin
                  rsp_in.status   = gtls_pkg::ST_LISTED;
                  rsp_in.item_res = gtls_pkg::ITEM_W'(pend_item_ff);
               end else begin
                  rsp_in.status = gtls_pkg::ST_NOMATCH;
               end
            end
            gtls_pkg::OP_REMOVE: begin
               rsp_in.removed_count = gtls_pkg::REMOVED_W'(count_ff - w_ff);
               count_in             = w_ff;
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = (cmd.emit_mid || cmd.emit_end) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         w_ff          <= '0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         i_ff          <= i_in;
         w_ff          <= w_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      grp_ff       <= grp_in;
      full_ff      <= full_in;
      pend_item_ff <= pend_item_in;
      rsp_ff       <= rsp_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_item[wr_addr]  <= wr_item;
         mem_group[wr_addr] <= wr_group;
      end
      rd_item_ff  <= mem_item[rd_addr];
      rd_group_ff <= mem_group[rd_addr];
   end

   assign stat.req_op     = req_data.operation;
   assign stat.op         = op_ff;
   assign stat.scan_end   = (i_ff >= count_ff);
   assign stat.is_match   = is_match;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the group tagged list store: directed and random
// append, list, remove and clear traffic with random idling on both channels
// depends on gtls_pkg and the group_tagged_list_store top level
`timescale 1ns / 100ps

module testbench;
   import gtls_pkg::*;

   // tracks the stored list and the responses each accepted request is due
   class group_list_tracker;
      logic [ITEM_W-1:0]  stored_item  [DEPTH_DEF];
      logic [GROUP_W-1:0] stored_group [DEPTH_DEF];
      int                 stored_count;
      rsp_type            due_responses [$];
      int                 errors;

      function new();
         stored_count = 0;
         errors = 0;
      endfunction

      function int pending();
         return due_responses.size();
      endfunction

      function void add_response(logic [STATUS_W-1:0] status, logic [ITEM_W-1:0] item,
                                 logic [REMOVED_W-1:0] removed, logic last);
         rsp_type e;
         e.status = status;
         e.item_res = item;
         e.removed_count = removed;
         e.last = last;
         due_responses.push_back(e);
      endfunction

      // work out the responses of one accepted request and update the list
      function void note_request(req_type r);
         int hits;
         int seen;
         int kept;
         case (r.operation)
            OP_APPEND: begin
               if (stored_count >= DEPTH_DEF) begin
                  add_response(ST_FULL, '0, '0, 1'b1);
               end else begin
                  stored_item[stored_count] = r.item;
                  stored_group[stored_count] = r.group;
                  stored_count++;
                  add_response(ST_OK, '0, '0, 1'b1);
               end
            end
            OP_LIST: begin
               hits = 0;
               for (int i = 0; i < stored_count; i++)
                  if (stored_group[i] == r.group) hits++;
               if (hits == 0) begin
                  add_response(ST_NOMATCH, '0, '0, 1'b1);
               end else begin
                  seen = 0;
                  for (int i = 0; i < stored_count; i++) begin
                     if (stored_group[i] == r.group) begin
                        seen++;
                        add_response(ST_LISTED, stored_item[i], '0, seen == hits);
                     end
                  end
               end
            end
            OP_REMOVE: begin
               // compact the survivors toward the head, order kept
               kept = 0;
               for (int i = 0; i < stored_count; i++) begin
                  if (stored_group[i] != r.group) begin
                     stored_item[kept] = stored_item[i];
                     stored_group[kept] = stored_group[i];
                     kept++;
                  end
               end
               add_response(ST_OK, '0, REMOVED_W'(stored_count - kept), 1'b1);
               stored_count = kept;
            end
            default: begin
               stored_count = 0;
               add_response(ST_OK, '0, '0, 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one accepted response with the oldest one due
      function void check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("item_res", want.item_res, got.item_res);
         compare_field("removed_count", 16'(want.removed_count), 16'(got.removed_count));
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    quiet = 1'b0;

   group_list_tracker tracker;

   group_tagged_list_store u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // receiver stalls at random except in the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99, 0) < 34);
   end

   // observe every transaction on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
      end
   end

   function automatic req_type make_req(logic [OP_W-1:0] op, logic [ITEM_W-1:0] item,
                                        logic [GROUP_W-1:0] group);
      req_type r;
      r.operation = op;
      r.item = item;
      r.group = group;
      return r;
   endfunction

   // present one request and hold it until it is taken
   task automatic send_item(input req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold the sender off until every due response has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   // empty-store cases, a full store, extreme values and tags
   task automatic run_directed();
      logic [ITEM_W-1:0] item;
      send_item(make_req(OP_CLEAR, '0, 8'h00));
      send_item(make_req(OP_LIST, '0, 8'h03));
      send_item(make_req(OP_REMOVE, '0, 8'h03));
      for (int i = 0; i < DEPTH_DEF; i++) begin
         case (i)
            0: item = 16'h8000;
            1: item = 16'h7fff;
            2: item = 16'hffff;
            3: item = 16'h0000;
            default: item = 16'(i * 16'h0f0f) ^ 16'ha5a5;
         endcase
         send_item(make_req(OP_APPEND, item,
                            (i == 0 || i == DEPTH_DEF - 1) ? 8'h00 : 8'hff));
      end
      send_item(make_req(OP_APPEND, 16'h1357, 8'h42));
      send_item(make_req(OP_LIST, '0, 8'hff));
      send_item(make_req(OP_LIST, '0, 8'h00));
      send_item(make_req(OP_REMOVE, '0, 8'h00));
      send_item(make_req(OP_LIST, '0, 8'h00));
      send_item(make_req(OP_CLEAR, '0, 8'h00));
   endtask

   // bursts over a small pool of tags so lists and removes find matches
   task automatic run_random(input int total);
      int                 sent;
      int                 burst_left;
      int                 pool_size;
      int                 pick;
      logic [GROUP_W-1:0] pool [4];
      req_type            r;
      sent = 0;
      burst_left = 0;
      pool_size = 1;
      while (sent < total) begin
         if (burst_left == 0) begin
            pool_size = $urandom_range(4, 1);
            for (int k = 0; k < 4; k++) pool[k] = GROUP_W'($urandom_range(255, 0));
            burst_left = $urandom_range(40, 10);
         end
         pick = $urandom_range(99, 0);
         r.item = ITEM_W'($urandom);
         r.group = pool[$urandom_range(pool_size - 1, 0)];
         if (pick < 55) r.operation = OP_APPEND;
         else if (pick < 80) r.operation = OP_LIST;
         else if (pick < 90) r.operation = OP_REMOVE;
         else if (pick < 93) r.operation = OP_CLEAR;
         else begin
            // noise: list or remove an arbitrary tag
            r.operation = pick[0] ? OP_LIST : OP_REMOVE;
            r.group = GROUP_W'($urandom);
         end
         quiet = (sent >= 120 && sent < 200);
         send_item(r);
         sent++;
         burst_left--;
         if (sent == total / 2) drain_results();
         else if (!quiet && $urandom_range(99, 0) < 34) pause_sender($urandom_range(4, 1));
      end
      quiet = 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      drain_results();
      run_random(330);
      drain_results();
      repeat (40) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("** group_tagged_list_store: PASSED **");
      end else begin
         $display("** group_tagged_list_store: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("** group_tagged_list_store: FAILED **");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/gtls_pkg.sv
design/gtls_ctrl.sv
design/gtls_dp.sv
design/group_tagged_list_store.sv
tb/sv/testbench.sv
